// ----- sv/clft_pkg.sv -----
// Shared types, constants and lookup functions for the character LCD terminal.
`timescale 1ns / 1ps

package clft_pkg;

    localparam int LINE_CHARS = 16;
    localparam int ROWS       = 2;
    localparam int MAX_XFERS  = 48;

    // LCD command and character bytes
    localparam logic [7:0] CMD_ROW0     = 8'h80;
    localparam logic [7:0] CMD_ROW1     = 8'hc0;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0c;
    localparam logic [7:0] CMD_DISP_CUR = 8'h0f;
    localparam logic [7:0] CMD_SHIFT    = 8'h14;
    localparam logic [7:0] CMD_FUNC     = 8'h28;
    localparam logic [7:0] CMD_CGRAM    = 8'h40;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;
    localparam logic [7:0] CH_HEX_A     = 8'h57;  // 'a' - 10
    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_4BIT     = 4'h2;

    typedef enum logic [2:0] {
        OP_PUT     = 3'd0,
        OP_GOTO    = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_CLR_EOL = 3'd3,
        OP_HEX     = 3'd4,
        OP_INIT    = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LONE,
        S_INIT,
        S_GLYPH,
        S_CLEAR,
        S_CHAR,
        S_ROW,
        S_GOTO,
        S_PAD
    } t_state;

    typedef enum logic [2:0] {
        B_LONE,
        B_INIT,
        B_GLYPH,
        B_CLEAR,
        B_CHAR,
        B_ROW,
        B_GOTO,
        B_PAD
    } t_byte_sel;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_byte_sel sel;
        logic [3:0] idx;
        logic      lo;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        t_op        in_op;
        logic       in_clear;
        logic       in_tab;
        logic       goto_ok;
        logic       pad_start;
        logic       wrap;
        logic [5:0] col_next;
        logic       out_room;
    } t_dp_sts;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx, input logic show);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CMD_ENTRY;
            3'd1:    b = show ? CMD_DISP_CUR : CMD_DISP_ON;
            3'd2:    b = CMD_SHIFT;
            3'd3:    b = CMD_FUNC;
            3'd4:    b = CMD_CGRAM;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Two 8-row glyphs; idx[3] picks the glyph, idx[2:0] the row
    function automatic logic [7:0] glyph_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx[2:0])
            3'd0:    b = 8'h00;
            3'd1:    b = idx[3] ? 8'h0f : 8'h00;
            3'd2:    b = 8'h00;
            3'd3:    b = 8'h1c;
            3'd4:    b = 8'h10;
            3'd5:    b = 8'h18;
            3'd6:    b = 8'h10;
            default: b = 8'h1c;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/clft_ctrl.sv -----
// Sequencer: steps through the nibble transfers of each terminal operation.
`timescale 1ns / 1ps

module clft_ctrl import clft_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic       r_lo, n_lo;
    logic [5:0] r_cnt, n_cnt;   // transfers emitted for the current item

    logic [2:0] pad_need;
    logic       pad_more;

    // budget check for the next space of a clear to end
    always_comb begin
        pad_need = (({1'b0, i_sts.col_next} + 7'd1) >= 7'(LINE_CHARS)) ? 3'd4 : 3'd2;
        pad_more = (i_sts.col_next != 6'd0) &&
                   (({1'b0, r_cnt} + 7'd1 + {4'b0, pad_need}) <= 7'(MAX_XFERS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_lo    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_lo    <= n_lo;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    n_lo  = 1'b0;
                    n_cnt = '0;
                    unique case (i_sts.in_op)
                        OP_PUT: begin
                            priority if (i_sts.in_clear) n_state = S_CLEAR;
                            else if (i_sts.in_tab)       n_state = S_ROW;
                            else                         n_state = S_CHAR;
                        end
                        OP_GOTO:    n_state = i_sts.goto_ok ? S_GOTO : S_IDLE;
                        OP_CLEAR:   n_state = S_CLEAR;
                        OP_CLR_EOL: n_state = i_sts.pad_start ? S_PAD : S_IDLE;
                        OP_HEX:     n_state = S_CHAR;
                        OP_INIT:    n_state = S_LONE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            default: begin
                if (i_sts.out_room) begin
                    n_cnt = r_cnt + 6'd1;
                    if (r_state == S_LONE) begin
                        if (r_idx == 4'd3) begin
                            n_state = S_INIT;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end else if (!r_lo) begin
                        n_lo = 1'b1;
                    end else begin
                        n_lo = 1'b0;
                        unique case (r_state)
                            S_INIT: begin
                                if (r_idx == 4'd4) begin
                                    n_state = S_GLYPH;
                                    n_idx   = '0;
                                end else begin
                                    n_idx = r_idx + 4'd1;
                                end
                            end
                            S_GLYPH: begin
                                if (r_idx == 4'd15) n_state = S_CLEAR;
                                n_idx = r_idx + 4'd1;
                            end
                            S_CHAR:  n_state = i_sts.wrap ? S_ROW : S_IDLE;
                            S_PAD: begin
                                priority if (i_sts.wrap) n_state = S_ROW;
                                else if (pad_more)       n_state = S_PAD;
                                else                     n_state = S_IDLE;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.emit = (r_state != S_IDLE) && i_sts.out_room;
        o_cmd.idx  = r_idx;
        o_cmd.lo   = r_lo;
        unique case (r_state)
            S_LONE: begin
                o_cmd.sel  = B_LONE;
                o_cmd.last = 1'b0;
            end
            S_INIT: begin
                o_cmd.sel  = B_INIT;
                o_cmd.last = 1'b0;
            end
            S_GLYPH: begin
                o_cmd.sel  = B_GLYPH;
                o_cmd.last = 1'b0;
            end
            S_CLEAR: begin
                o_cmd.sel  = B_CLEAR;
                o_cmd.last = r_lo;
            end
            S_CHAR: begin
                o_cmd.sel  = B_CHAR;
                o_cmd.last = r_lo && !i_sts.wrap;
            end
            S_ROW: begin
                o_cmd.sel  = B_ROW;
                o_cmd.last = r_lo;
            end
            S_GOTO: begin
                o_cmd.sel  = B_GOTO;
                o_cmd.last = r_lo;
            end
            S_PAD: begin
                o_cmd.sel  = B_PAD;
                o_cmd.last = r_lo && !i_sts.wrap && !pad_more;
            end
            default: begin
                o_cmd.sel  = B_LONE;
                o_cmd.last = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/clft_dp.sv -----
// Datapath: item latch, cursor, byte/nibble formation and output register.
`timescale 1ns / 1ps

module clft_dp import clft_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic [2:0] i_op,
    input  logic [7:0] i_char_code,
    input  logic       i_target_row,
    input  logic [5:0] i_target_col,
    input  logic       i_clear_row,
    input  logic [3:0] i_hex_value,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_reg_select,
    output logic [3:0] o_nibble,
    output logic       o_busy_poll_after,
    output logic       o_last
);

    logic       r_show;
    logic       r_row;
    logic [5:0] r_col;
    logic [7:0] r_char;
    logic       r_trow;
    logic [5:0] r_tcol;

    logic       r_valid;
    logic       r_rs;
    logic [3:0] r_nib;
    logic       r_busy;
    logic       r_last;

    logic       other_row;
    logic [7:0] hex_char;
    logic [7:0] xbyte;
    logic       rs;
    logic [3:0] nib;
    logic       busy;

    assign other_row = (ROWS > 1) && !r_row;
    assign hex_char  = (i_hex_value <= 4'd9) ? (CH_DIGIT0 + {4'b0, i_hex_value})
                                              : (CH_HEX_A + {4'b0, i_hex_value});

    always_comb begin
        o_sts.in_op     = t_op'(i_op);
        o_sts.in_clear  = (i_char_code == CH_CR) || (i_char_code == CH_LF);
        o_sts.in_tab    = (i_char_code == CH_TAB);
        o_sts.goto_ok   = ({1'b0, i_target_row} < 2'(ROWS)) &&
                          ({1'b0, i_target_col} < 7'(LINE_CHARS));
        o_sts.pad_start = (r_col != 6'd0) && (r_row == i_clear_row);
        o_sts.col_next  = r_col + 6'd1;
        o_sts.wrap      = ({1'b0, o_sts.col_next} >= 7'(LINE_CHARS));
        o_sts.out_room  = !r_valid || i_ready;
    end

    always_comb begin
        unique case (i_cmd.sel)
            B_INIT:  xbyte = init_cmd(i_cmd.idx[2:0], r_show);
            B_GLYPH: xbyte = glyph_byte(i_cmd.idx);
            B_CLEAR: xbyte = CMD_CLEAR;
            B_CHAR:  xbyte = r_char;
            B_PAD:   xbyte = CH_SPACE;
            B_ROW:   xbyte = other_row ? CMD_ROW1 : CMD_ROW0;
            B_GOTO:  xbyte = CMD_ROW0 + {1'b0, r_trow, 6'b0} + {2'b0, r_tcol};
            default: xbyte = 8'h00;
        endcase
        rs   = (i_cmd.sel == B_CHAR) || (i_cmd.sel == B_PAD) || (i_cmd.sel == B_GLYPH);
        busy = (i_cmd.sel != B_LONE) && i_cmd.lo;
        if (i_cmd.sel == B_LONE) begin
            nib = (i_cmd.idx == 4'd3) ? NIB_4BIT : NIB_WAKE;
        end else begin
            nib = i_cmd.lo ? xbyte[3:0] : xbyte[7:4];
        end
    end

    // config register, cursor and item latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show <= 1'b0;
            r_row  <= 1'b0;
            r_col  <= '0;
        end else begin
            if (i_cfg_wr_en) r_show <= i_cfg_wr_data;
            if (i_cmd.emit && i_cmd.lo) begin
                unique case (i_cmd.sel)
                    B_CHAR, B_PAD: r_col <= o_sts.col_next;
                    B_ROW: begin
                        r_row <= other_row;
                        r_col <= '0;
                    end
                    B_CLEAR: begin
                        r_row <= 1'b0;
                        r_col <= '0;
                    end
                    B_GOTO: begin
                        r_row <= r_trow;
                        r_col <= r_tcol;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= (t_op'(i_op) == OP_HEX) ? hex_char : i_char_code;
            r_trow <= i_target_row;
            r_tcol <= i_target_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rs   <= rs;
            r_nib  <= nib;
            r_busy <= busy;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid           = r_valid;
    assign o_reg_select      = r_rs;
    assign o_nibble          = r_nib;
    assign o_busy_poll_after = r_busy;
    assign o_last            = r_last;

endmodule

// ----- sv/char_lcd_four_bit_terminal.sv -----
// Top level of the 4-bit character LCD terminal: sequencer plus datapath.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one terminal operation per
//   transaction: put char, go to, clear, clear to end, hex digit, init.
//   Output channel (o_valid/i_ready) gives one LCD nibble transfer per
//   transaction, with o_last set on the final transfer of an operation.
//   Operations that cause no transfer (bad go to, empty clear to end,
//   unknown op) produce nothing and leave the input free.
//   The first transfer of an operation passes the sequencer state register
//   and then the output register. Transfers then come one per cycle while
//   i_ready is high; init is the longest at 48 transfers. One operation is
//   worked at a time, paced by the single-nibble output register.
//   A stalled receiver freezes the sequencer; the pending transfer holds.
//   The next operation is taken while the last transfer still waits.
//   Reset: cursor to row 0 column 0, show_cursor_blink to 0, output empty.
//   i_cfg_wr_en/i_cfg_wr_data write show_cursor_blink; the user must do so only while idle.
`timescale 1ns / 1ps

module char_lcd_four_bit_terminal import clft_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_op,
    input  logic [7:0] i_char_code,
    input  logic       i_target_row,
    input  logic [5:0] i_target_col,
    input  logic       i_clear_row,
    input  logic [3:0] i_hex_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_reg_select,
    output logic [3:0] o_nibble,
    output logic       o_busy_poll_after,
    output logic       o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    clft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    clft_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_op              (i_op),
        .i_char_code       (i_char_code),
        .i_target_row      (i_target_row),
        .i_target_col      (i_target_col),
        .i_clear_row       (i_clear_row),
        .i_hex_value       (i_hex_value),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_reg_select      (o_reg_select),
        .o_nibble          (o_nibble),
        .o_busy_poll_after (o_busy_poll_after),
        .o_last            (o_last)
    );

    // a new transfer never overwrites one that is still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_room)
        else $error("transfer loaded over a pending one");

    // the final transfer of an operation frees the input channel
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && cmd.last |=> o_ready)
        else $error("input not freed after final transfer");

    // cursor column never passes the line length (it sits there only during a wrap)
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, sts.col_next} <= 7'(LINE_CHARS + 1))
        else $error("cursor column out of range");

    // busy poll marker only on the low nibble of a full byte
    a_busy_on_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && cmd.sel == B_LONE |=> !o_busy_poll_after)
        else $error("busy poll marked on a lone nibble");

endmodule
